/* src/sau_pkg.sv */
// Shared types and constants of the stack arithmetic unit.
package sau_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int TOP_W    = 32;
  localparam int DEPTH_W  = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MOD  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic              start;
    logic [KIND_W-1:0] kind;
  } alu_req_t;

endpackage

/* src/sau_alu.sv */
// Iterative arithmetic unit: one shared adder does sub, shift-add mul and restoring div/mod.
module sau_alu #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sau_pkg::alu_req_t     req,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] result
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(WORD_WIDTH);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_SUB  = 3'd1;
  localparam logic [2:0] A_ABSA = 3'd2;
  localparam logic [2:0] A_ABSB = 3'd3;
  localparam logic [2:0] A_MUL  = 3'd4;
  localparam logic [2:0] A_DIV  = 3'd5;
  localparam logic [2:0] A_FIX  = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  q;
  logic [W-1:0]  m;
  logic          neg;
  logic          is_mod;

  logic [W-1:0]  add_x;
  logic [W-1:0]  add_y;
  logic          add_inv;
  logic [W:0]    y_ext;
  logic [W:0]    sum;
  logic [W-1:0]  rem_sh;

  assign rem_sh = {acc[W-2:0], q[W-1]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_inv = 1'b0;
    case (state)
      A_SUB: begin
        add_x   = q;
        add_y   = m;
        add_inv = 1'b1;
      end
      A_ABSA: begin
        add_y   = q;
        add_inv = q[W-1];
      end
      A_ABSB: begin
        add_y   = m;
        add_inv = m[W-1];
      end
      A_MUL: begin
        add_x = acc;
        add_y = m;
      end
      A_DIV: begin
        add_x   = rem_sh;
        add_y   = m;
        add_inv = 1'b1;
      end
      A_FIX: begin
        add_y   = is_mod ? acc : q;
        add_inv = neg;
      end
      default: begin
        add_x   = '0;
      end
    endcase
    y_ext = {1'b0, add_y};
    sum   = {1'b0, add_x} + (add_inv ? ~y_ext : y_ext) + (W+1)'(add_inv);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            cnt <= CW'(W - 1);
            if (req.kind == sau_pkg::KIND_SUB) begin
              state <= A_SUB;
            end else if (req.kind == sau_pkg::KIND_MUL) begin
              state <= A_MUL;
            end else begin
              state <= A_ABSA;
            end
          end
        end
        A_SUB: begin
          done  <= 1'b1;
          state <= A_IDLE;
        end
        A_ABSA: state <= A_ABSB;
        A_ABSB: state <= A_DIV;
        A_MUL: begin
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= A_IDLE;
          end
        end
        A_DIV: begin
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          q      <= a;
          m      <= b;
          acc    <= '0;
          is_mod <= (req.kind == sau_pkg::KIND_MOD);
          neg    <= (req.kind == sau_pkg::KIND_MOD) ? a[W-1] : (a[W-1] ^ b[W-1]);
        end
      end
      A_SUB: result <= sum[W-1:0];
      A_ABSA: q <= sum[W-1:0];
      A_ABSB: m <= sum[W-1:0];
      A_MUL: begin
        // add the shifted multiplicand where the multiplier bit is set
        if (q[0]) begin
          acc <= sum[W-1:0];
        end
        m      <= m << 1;
        q      <= q >> 1;
        result <= q[0] ? sum[W-1:0] : acc;
      end
      A_DIV: begin
        // keep the trial difference when it does not go negative
        acc <= sum[W] ? rem_sh : sum[W-1:0];
        q   <= {q[W-2:0], ~sum[W]};
      end
      A_FIX: result <= sum[W-1:0];
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

/* src/stack_arithmetic_unit.sv */
// Top level of the stack arithmetic unit: stack memory, depth counter and item sequencer.
//
// Usage: the input channel (in_valid/in_stall, kind, push_value) carries one operation per
// item: push, sub, mul, div or mod. Every accepted item yields exactly one result item on the
// output channel (out_valid/out_stall, status, top_value, stack_depth) reporting the status,
// the new top of stack (zero when empty) and the entry count.
// Work per item: push, an unused kind and a short stack need no arithmetic, nor does
// division by zero; mul takes one shift-add step per bit, and div and mod take two sign
// steps, one restoring step per bit and one sign fix.
// One item is in flight at a time; in_stall is high from acceptance until the result is
// loaded into the output register, so a new item can be taken in the cycle in which the
// last one's result appears.
// If the receiver stalls, the result holds in the output register and the next item may
// still be accepted and worked; it waits to be loaded until the register frees.
// Reset empties the stack and drops any pending result; stack entries are not cleared.
module stack_arithmetic_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sau_pkg::KIND_W-1:0]          kind,
  input  logic signed [31:0]                  push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sau_pkg::STATUS_W-1:0]        status,
  output logic signed [sau_pkg::TOP_W-1:0]    top_value,
  output logic [sau_pkg::DEPTH_W-1:0]         stack_depth
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int TW = sau_pkg::TOP_W;
  localparam int OW = sau_pkg::DEPTH_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                     state;
  logic [DW-1:0]                  depth_count;
  logic [WORD_WIDTH-1:0]          top_word;
  logic [WORD_WIDTH-1:0]          rd_data;
  logic [sau_pkg::KIND_W-1:0]     kind_r;
  logic [sau_pkg::STATUS_W-1:0]   status_r;

  logic [WORD_WIDTH-1:0]          stack_mem [STACK_DEPTH];

  logic                           accept;
  logic                           is_full;
  logic                           is_short;
  logic [DW-1:0]                  depth_m2;
  logic [AW-1:0]                  second_addr;
  logic [WORD_WIDTH-1:0]          push_word;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [WORD_WIDTH-1:0]          wr_data;
  logic                           out_room;
  logic                           is_divide;

  sau_pkg::alu_req_t              alu_req;
  logic                           alu_done;
  logic [WORD_WIDTH-1:0]          alu_result;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && (state == S_IDLE);
  assign is_full     = (depth_count == DW'(STACK_DEPTH));
  assign is_short    = (depth_count < DW'(2));
  assign depth_m2    = depth_count - DW'(2);
  assign second_addr = depth_m2[AW-1:0];
  assign push_word   = WORD_WIDTH'(push_value);
  assign out_room    = !out_valid || !out_stall;
  assign is_divide   = (kind_r == sau_pkg::KIND_DIV) || (kind_r == sau_pkg::KIND_MOD);

  // Start the shared unit once the second operand is out of memory and, for div and mod, the divisor is nonzero
  assign alu_req.start = (state == S_READ) && !(is_divide && (top_word == '0));
  assign alu_req.kind  = kind_r;

  sau_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rd_data),
    .b      (top_word),
    .done   (alu_done),
    .result (alu_result)
  );

  // Single write port: a push writes above the top, an operation overwrites the second entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = depth_count[AW-1:0];
    wr_data = push_word;
    if (accept && (kind == sau_pkg::KIND_PUSH) && !is_full) begin
      wr_en = 1'b1;
    end else if ((state == S_WAIT) && alu_done) begin
      wr_en   = 1'b1;
      wr_addr = second_addr;
      wr_data = alu_result;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[second_addr];
  end

  // Sequencer and stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == sau_pkg::KIND_PUSH) begin
              if (!is_full) begin
                depth_count <= depth_count + DW'(1);
              end
              state <= S_DONE;
            end else if ((kind > sau_pkg::KIND_MOD) || is_short) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= alu_req.start ? S_WAIT : S_DONE;
        S_WAIT: begin
          if (alu_done) begin
            depth_count <= depth_count - DW'(1);
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_room) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Cached top word and item status
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_r <= kind;
        if (accept) begin
          if (kind == sau_pkg::KIND_PUSH) begin
            status_r <= is_full ? sau_pkg::ST_FULL : sau_pkg::ST_OK;
            if (!is_full) begin
              top_word <= push_word;
            end
          end else if (kind > sau_pkg::KIND_MOD) begin
            status_r <= sau_pkg::ST_OK;
          end else if (is_short) begin
            status_r <= sau_pkg::ST_SHORT;
          end else begin
            status_r <= sau_pkg::ST_OK;
          end
        end
      end
      S_READ: begin
        if (!alu_req.start) begin
          status_r <= sau_pkg::ST_DIVZERO;
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          top_word <= alu_result;
        end
      end
      default: begin
        top_word <= top_word;
      end
    endcase
  end

  // Output register: load when free or being taken, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_room) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_room) begin
      status      <= status_r;
      top_value   <= (depth_count != '0) ? TW'($signed(top_word)) : '0;
      stack_depth <= OW'(depth_count);
    end
  end

endmodule
